FILE: design/hrp_pkg.sv
`default_nettype none
package hrp_pkg;

  // saturating byte counter width; the result field is fixed at 20 bits
  localparam int COUNT_BITS  = 20;
  localparam int OUT_COUNT_W = 20;

  // front-to-back queue, in result bundles
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef enum logic [3:0] {
    PH_METHOD,
    PH_PATH,
    PH_QUERY,
    PH_MATCH,
    PH_VERSION,
    PH_REST,
    PH_NAME,
    PH_VSKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    K_METHOD       = 4'd0,
    K_PATH         = 4'd1,
    K_QUERY        = 4'd2,
    K_VERSION      = 4'd3,
    K_NAME         = 4'd4,
    K_VALUE        = 4'd5,
    K_HDR_DONE     = 4'd6,
    K_DISCARD      = 4'd7,
    K_DEFAULT_PATH = 4'd8,
    K_REQ_DONE     = 4'd9,
    K_HEAD_DONE    = 4'd10
  } kind_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             value;
    logic [OUT_COUNT_W-1:0] byte_count;
    logic                   last;
  } result_t;

  // one input byte yields at most two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t data;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_rd_t;

endpackage
`default_nettype wire

FILE: design/hrp_if.sv
`default_nettype none
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface hrp_out_if;
  logic                            valid;
  logic                            ready;
  logic [3:0]                      kind;
  logic [7:0]                      value;
  logic [hrp_pkg::OUT_COUNT_W-1:0] byte_count;
  logic                            last;

  modport source (output valid, kind, value, byte_count, last, input ready);
  modport sink   (input valid, kind, value, byte_count, last, output ready);
endinterface
`default_nettype wire

FILE: design/hrp_front.sv
`default_nettype none
module hrp_front import hrp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  hrp_in_if.sink in_ch,
  input  logic   q_full,
  output q_wr_t  q_wr
);

  typedef struct packed {
    phase_t     phase;
    logic [1:0] esc_cnt;
    logic [7:0] esc_c0;
    logic [2:0] match_idx;
    logic       nonempty;
  } st_t;

  typedef struct packed {
    st_t        st;
    logic [1:0] n;
    kind_t      k0;
    logic [7:0] v0;
    kind_t      k1;
    logic [7:0] v1;
  } step_t;

  localparam st_t ST_RESET = '{PH_METHOD, 2'd0, 8'd0, 3'd0, 1'b0};

  function automatic logic is_white(logic [7:0] c);
    return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  // strtoul-style: blanks, optional sign, hex digits; low byte kept
  function automatic logic [7:0] decode_escape(logic [7:0] c0, logic [7:0] c1, logic two);
    logic [7:0] ch [2];
    logic [1:0] i;
    logic [1:0] n;
    logic       neg;
    logic       any;
    logic       stop;
    logic [7:0] v;
    logic [4:0] d;
    ch[0] = c0;
    ch[1] = c1;
    n     = two ? 2'd2 : 2'd1;
    i     = 2'd0;
    neg   = 1'b0;
    any   = 1'b0;
    stop  = 1'b0;
    v     = 8'd0;
    for (int k = 0; k < 2; k++) begin
      if (i == 2'(k) && i < n && is_white(ch[k])) i = i + 2'd1;
    end
    if (i < n && (ch[i[0]] == CH_PLUS || ch[i[0]] == CH_MINUS)) begin
      neg = (ch[i[0]] == CH_MINUS);
      i   = i + 2'd1;
    end
    for (int k = 0; k < 2; k++) begin
      if (!stop && 2'(k) >= i && 2'(k) < n) begin
        d = hex_val(ch[k]);
        if (d[4]) begin
          stop = 1'b1;
        end else begin
          v   = {v[3:0], d[3:0]};
          any = 1'b1;
        end
      end
    end
    if (!any) v = 8'd0;
    else if (neg) v = 8'd0 - v;
    return v;
  endfunction

  function automatic logic [7:0] tag_char(logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h48;  // H
      3'd1:    r = 8'h54;  // T
      3'd2:    r = 8'h54;  // T
      3'd3:    r = 8'h50;  // P
      3'd4:    r = 8'h2F;  // /
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic step_t line_byte(st_t s, logic [7:0] c);
    step_t r;
    r    = '0;
    r.st = s;
    case (s.phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          r.st.phase   = PH_PATH;
          r.st.esc_cnt = 2'd0;
        end else begin
          r.n = 2'd1; r.k0 = K_METHOD; r.v0 = c;
        end
      end
      PH_PATH: begin
        if (s.esc_cnt == 2'd1) begin
          r.st.esc_c0  = c;
          r.st.esc_cnt = 2'd2;
        end else if (s.esc_cnt == 2'd2) begin
          r.n = 2'd1; r.k0 = K_PATH; r.v0 = decode_escape(s.esc_c0, c, 1'b1);
          r.st.esc_cnt = 2'd0;
        end else if (c == CH_PCT) begin
          r.st.esc_cnt = 2'd1;
        end else if (c == CH_QMARK) begin
          r.st.phase = PH_QUERY;
        end else if (c == CH_SP) begin
          r.st.phase     = PH_MATCH;
          r.st.match_idx = 3'd0;
        end else begin
          r.n = 2'd1; r.k0 = K_PATH; r.v0 = c;
        end
      end
      PH_QUERY: begin
        if (c == CH_SP) begin
          r.st.phase     = PH_MATCH;
          r.st.match_idx = 3'd0;
        end else begin
          r.n = 2'd1; r.k0 = K_QUERY; r.v0 = c;
        end
      end
      PH_MATCH: begin
        if (s.match_idx < 3'd5 && c == tag_char(s.match_idx)) begin
          r.st.match_idx = s.match_idx + 3'd1;
          if (s.match_idx == 3'd4) r.st.phase = PH_VERSION;
        end else begin
          r.st.phase = PH_REST;
        end
      end
      PH_VERSION: begin
        r.n = 2'd1; r.k0 = K_VERSION; r.v0 = c;
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          r.st.phase = PH_VSKIP;
        end else begin
          r.n = 2'd1; r.k0 = K_NAME; r.v0 = c;
        end
      end
      PH_VSKIP: begin
        if (c != CH_SP && c != CH_TAB) begin
          r.n = 2'd1; r.k0 = K_VALUE; r.v0 = c;
          r.st.phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        r.n = 2'd1; r.k0 = K_VALUE; r.v0 = c;
      end
      default: ;
    endcase
    r.st.nonempty = 1'b1;
    return r;
  endfunction

  function automatic step_t line_end(st_t s);
    step_t r;
    r    = '0;
    r.st = s;
    case (s.phase)
      PH_METHOD: begin
        if (s.nonempty) begin
          r.n = 2'd2; r.k0 = K_DEFAULT_PATH; r.k1 = K_REQ_DONE;
          r.st.phase = PH_NAME;
        end
      end
      PH_PATH: begin
        if (s.esc_cnt == 2'd1) begin
          r.n = 2'd2; r.k0 = K_PATH; r.k1 = K_REQ_DONE;
        end else if (s.esc_cnt == 2'd2) begin
          r.n = 2'd2; r.k0 = K_PATH; r.k1 = K_REQ_DONE;
          r.v0 = decode_escape(s.esc_c0, 8'd0, 1'b0);
        end else begin
          r.n = 2'd1; r.k0 = K_REQ_DONE;
        end
        r.st.esc_cnt = 2'd0;
        r.st.phase   = PH_NAME;
      end
      PH_QUERY, PH_MATCH, PH_VERSION, PH_REST: begin
        r.n = 2'd1; r.k0 = K_REQ_DONE;
        r.st.phase = PH_NAME;
      end
      PH_NAME: begin
        r.n = 2'd1;
        if (!s.nonempty) begin
          r.k0       = K_HEAD_DONE;
          r.st.phase = PH_DONE;
        end else begin
          r.k0 = K_DISCARD;
        end
      end
      PH_VSKIP, PH_VALUE: begin
        r.n = 2'd1; r.k0 = K_HDR_DONE;
        r.st.phase = PH_NAME;
      end
      default: ;
    endcase
    r.st.nonempty  = 1'b0;
    r.st.match_idx = 3'd0;
    return r;
  endfunction

  st_t        st_r, st_nxt;
  logic       held_r, held_nxt;
  count_t     cnt_r, cnt_nxt, cnt_inc;
  step_t      cr_step, byte_step;
  logic       fire, active, two, any_res;
  logic [7:0] c;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.data_byte;
  assign active      = fire && !in_ch.command && (st_r.phase != PH_DONE);
  assign cnt_inc     = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;

  // held CR goes first as a line byte unless this byte is LF
  always_comb begin
    cr_step    = '0;
    cr_step.st = st_r;
    if (held_r && c != CH_LF) cr_step = line_byte(st_r, CH_CR);
    if (c == CH_CR) begin
      byte_step    = '0;
      byte_step.st = cr_step.st;
    end else if (c == CH_LF) begin
      byte_step = line_end(cr_step.st);
    end else begin
      byte_step = line_byte(cr_step.st, c);
    end
  end

  always_comb begin
    st_nxt   = st_r;
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (fire && in_ch.command) begin
      st_nxt   = ST_RESET;
      held_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (active) begin
      st_nxt   = byte_step.st;
      held_nxt = (c == CH_CR);
      cnt_nxt  = cnt_inc;
    end
  end

  always_comb begin
    q_wr    = '0;
    any_res = (cr_step.n != 2'd0) || (byte_step.n != 2'd0);
    if (cr_step.n != 2'd0) begin
      two             = (byte_step.n != 2'd0);
      q_wr.data.r0.kind  = cr_step.k0;
      q_wr.data.r0.value = cr_step.v0;
      q_wr.data.r1.kind  = byte_step.k0;
      q_wr.data.r1.value = byte_step.v0;
    end else begin
      two             = (byte_step.n == 2'd2);
      q_wr.data.r0.kind  = byte_step.k0;
      q_wr.data.r0.value = byte_step.v0;
      q_wr.data.r1.kind  = byte_step.k1;
      q_wr.data.r1.value = byte_step.v1;
    end
    q_wr.push               = active && any_res;
    q_wr.data.two           = two;
    q_wr.data.r0.byte_count = OUT_COUNT_W'(cnt_inc);
    q_wr.data.r1.byte_count = OUT_COUNT_W'(cnt_inc);
    q_wr.data.r0.last       = !two;
    q_wr.data.r1.last       = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_RESET;
      held_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/hrp_queue.sv
`default_nettype none
module hrp_queue import hrp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t wr,
  output logic  full,
  output q_rd_t rd,
  input  logic  pop
);

  bundle_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign full     = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rd.valid = (cnt_r != '0);
  assign rd.data  = mem_r[rp_r];
  assign do_pop   = pop && rd.valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr.push) begin
      wp_nxt = (wp_r == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (wr.push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!wr.push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) mem_r[wp_r] <= wr.data;
  end

endmodule
`default_nettype wire

FILE: design/hrp_back.sv
`default_nettype none
module hrp_back import hrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_rd_t      rd,
  output logic       pop,
  hrp_out_if.source  out_ch
);

  logic    out_valid_r, out_valid_nxt;
  logic    pend_valid_r, pend_valid_nxt;
  result_t out_r, out_nxt;
  result_t pend_r, pend_nxt;
  logic    load;

  // output register frees when empty or when its transfer completes
  assign load = !out_valid_r || out_ch.ready;
  assign pop  = load && !pend_valid_r && rd.valid;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    pend_nxt       = pend_r;
    if (load) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        out_valid_nxt  = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (rd.valid) begin
        out_nxt        = rd.data.r0;
        out_valid_nxt  = 1'b1;
        pend_nxt       = rd.data.r1;
        pend_valid_nxt = rd.data.two;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.value      = out_r.value;
  assign out_ch.byte_count = out_r.byte_count;
  assign out_ch.last       = out_r.last;

endmodule
`default_nettype wire

FILE: design/http_request_head_parser_unit.sv
`default_nettype none
// Streaming HTTP request-head parser. Feed one byte per transfer on in_ch
// (command 0), or a restart (command 1) before each new head. Results on
// out_ch carry a kind code, the byte (method, percent-decoded path, raw
// query, version, header name or value) or zero for markers, the saturating
// count of bytes taken since restart, and last on the final result of each
// input byte. A byte gives zero, one or two results. The input side takes
// one byte per cycle; each byte is classified combinationally by the front
// state machine and its results are pushed as one bundle into a four-entry
// queue. The back end drains one result per cycle through a registered
// output, so a byte's results are written into the queue and then loaded
// into the output register before they are valid on out_ch. in_ch.ready
// drops only while the queue is full, which happens when two-result bytes
// or a stalled sink outrun the one-result-per-cycle drain. After the blank
// line that ends the head, bytes are taken and ignored until a restart.
// No clearing pass is needed after reset.
module http_request_head_parser_unit import hrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hrp_in_if.sink    in_ch,
  hrp_out_if.source out_ch
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // front: byte classification, parser state, byte counter
  hrp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // result bundles waiting for the output side
  hrp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .rd    (q_rd),
    .pop   (q_pop)
  );

  // back: splits bundles into single results behind an output register
  hrp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // a push into a full queue would drop a bundle
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("result bundle pushed into full queue");

  // every result comes from a counted byte
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (q_wr.data.r0.byte_count != '0))
    else $error("result with zero byte count");

  // a restart yields no results
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command) |-> !q_wr.push)
    else $error("restart produced results");

endmodule
`default_nettype wire

FILE: verif/hrp_tb_pkg.sv
`timescale 1ns / 1ps
package hrp_tb_pkg;

  // command field of an input transfer
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

endpackage

FILE: verif/hrp_result_checker.sv
`timescale 1ns / 1ps
module hrp_result_checker
  import hrp_pkg::*;
  import hrp_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hrp_in_if           in_ch,
  hrp_out_if          out_ch,
  output int unsigned error_count,
  output int unsigned outstanding
);

  localparam int          REPORT_MAX = 10;
  localparam logic [39:0] HTTP_TAG   = "HTTP/";

  // parser state mirrored from the spec
  phase_t     parse_phase;
  logic       cr_pending;
  logic [1:0] esc_count;
  logic [7:0] esc_first;
  logic [2:0] tag_pos;
  logic       line_has_text;
  count_t     bytes_taken;

  result_t step_toks[$];
  result_t token_q[$];

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SP || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // strtoul(.., 16) over one or two chars, low byte kept
  function automatic logic [7:0] unescape(input logic [7:0] c0, input logic [7:0] c1,
                                          input int n);
    logic [7:0] ch[2];
    logic [4:0] d;
    logic [7:0] v;
    int         i;
    bit         neg;
    bit         any;
    ch[0] = c0;
    ch[1] = c1;
    i     = 0;
    neg   = 1'b0;
    any   = 1'b0;
    v     = 8'd0;
    while (i < n && blank_char(ch[i])) i++;
    if (i < n && (ch[i] == CH_PLUS || ch[i] == CH_MINUS)) begin
      neg = (ch[i] == CH_MINUS);
      i++;
    end
    while (i < n && hex_val(ch[i]) < 5'd16) begin
      d   = hex_val(ch[i]);
      v   = {v[3:0], d[3:0]};
      any = 1'b1;
      i++;
    end
    if (!any) return 8'd0;
    if (neg) v = -v;
    return v;
  endfunction

  task automatic reset_parser();
    parse_phase   = PH_METHOD;
    cr_pending    = 1'b0;
    esc_count     = 2'd0;
    esc_first     = 8'd0;
    tag_pos       = 3'd0;
    line_has_text = 1'b0;
    bytes_taken   = '0;
  endtask

  task automatic add_token(input kind_t k, input logic [7:0] v);
    result_t t;
    t.kind       = k;
    t.value      = v;
    t.byte_count = OUT_COUNT_W'(bytes_taken);
    t.last       = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic take_line_byte(input logic [7:0] c);
    case (parse_phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          parse_phase = PH_PATH;
          esc_count   = 2'd0;
        end else add_token(K_METHOD, c);
      end
      PH_PATH: begin
        if (esc_count == 2'd1) begin
          esc_first = c;
          esc_count = 2'd2;
        end else if (esc_count == 2'd2) begin
          add_token(K_PATH, unescape(esc_first, c, 2));
          esc_count = 2'd0;
        end else if (c == CH_PCT) esc_count = 2'd1;
        else if (c == CH_QMARK) parse_phase = PH_QUERY;
        else if (c == CH_SP) begin
          parse_phase = PH_MATCH;
          tag_pos     = 3'd0;
        end else add_token(K_PATH, c);
      end
      PH_QUERY: begin
        if (c == CH_SP) begin
          parse_phase = PH_MATCH;
          tag_pos     = 3'd0;
        end else add_token(K_QUERY, c);
      end
      PH_MATCH: begin
        if (tag_pos < 3'd5 && c == HTTP_TAG[39 - 8*tag_pos -: 8]) begin
          tag_pos++;
          if (tag_pos == 3'd5) parse_phase = PH_VERSION;
        end else parse_phase = PH_REST;
      end
      PH_VERSION: add_token(K_VERSION, c);
      PH_NAME: begin
        if (c == CH_COLON) parse_phase = PH_VSKIP;
        else add_token(K_NAME, c);
      end
      PH_VSKIP: begin
        if (c != CH_SP && c != CH_TAB) begin
          add_token(K_VALUE, c);
          parse_phase = PH_VALUE;
        end
      end
      PH_VALUE: add_token(K_VALUE, c);
      default: ;
    endcase
    line_has_text = 1'b1;
  endtask

  task automatic take_line_end();
    case (parse_phase)
      PH_METHOD: begin
        // blank lines ahead of the request line are skipped
        if (line_has_text) begin
          add_token(K_DEFAULT_PATH, 8'd0);
          add_token(K_REQ_DONE, 8'd0);
          parse_phase = PH_NAME;
        end
      end
      PH_PATH: begin
        if (esc_count == 2'd1) add_token(K_PATH, 8'd0);
        else if (esc_count == 2'd2) add_token(K_PATH, unescape(esc_first, 8'd0, 1));
        esc_count = 2'd0;
        add_token(K_REQ_DONE, 8'd0);
        parse_phase = PH_NAME;
      end
      PH_QUERY, PH_MATCH, PH_VERSION, PH_REST: begin
        add_token(K_REQ_DONE, 8'd0);
        parse_phase = PH_NAME;
      end
      PH_NAME: begin
        if (!line_has_text) begin
          add_token(K_HEAD_DONE, 8'd0);
          parse_phase = PH_DONE;
        end else add_token(K_DISCARD, 8'd0);
      end
      PH_VSKIP, PH_VALUE: begin
        add_token(K_HDR_DONE, 8'd0);
        parse_phase = PH_NAME;
      end
      default: ;
    endcase
    line_has_text = 1'b0;
    tag_pos       = 3'd0;
  endtask

  task automatic parse_item(input logic cmd, input logic [7:0] c);
    result_t t;
    step_toks.delete();
    if (cmd == CMD_RESTART) begin
      reset_parser();
      return;
    end
    if (parse_phase == PH_DONE) return;
    if (bytes_taken != '1) bytes_taken++;
    // a held CR is dropped only when LF follows
    if (cr_pending) begin
      cr_pending = 1'b0;
      if (c != CH_LF) take_line_byte(CH_CR);
    end
    if (c == CH_CR) cr_pending = 1'b1;
    else if (c == CH_LF) take_line_end();
    else take_line_byte(c);
    if (step_toks.size() > 0) begin
      t      = step_toks[step_toks.size() - 1];
      t.last = 1'b1;
      step_toks[step_toks.size() - 1] = t;
    end
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endtask

  task automatic count_error();
    error_count++;
  endtask

  initial begin
    error_count = 0;
    outstanding = 0;
    reset_parser();
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      reset_parser();
      token_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (token_q.size() == 0) begin
          count_error();
          if (error_count <= REPORT_MAX)
            $display("%0t: unexpected result kind %0d value %02h count %0d last %0b",
                     $realtime, out_ch.kind, out_ch.value, out_ch.byte_count, out_ch.last);
        end else begin
          want = token_q.pop_front();
          if (out_ch.kind !== want.kind || out_ch.value !== want.value ||
              out_ch.byte_count !== want.byte_count || out_ch.last !== want.last) begin
            count_error();
            if (error_count <= REPORT_MAX)
              $display("%0t: mismatch exp kind %0d value %02h count %0d last %0b, %s",
                       $realtime, want.kind, want.value, want.byte_count, want.last,
                       $sformatf("got kind %0d value %02h count %0d last %0b",
                                 out_ch.kind, out_ch.value, out_ch.byte_count,
                                 out_ch.last));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) parse_item(in_ch.command, in_ch.data_byte);
    end
    outstanding = token_q.size();
  end

endmodule

FILE: verif/tb_http_request_head_parser_unit.sv
`timescale 1ns / 1ps
module tb_http_request_head_parser_unit;
  import hrp_pkg::*;
  import hrp_tb_pkg::*;

  // run shape
  localparam int          RANDOM_ITEMS = 470;
  localparam int          NUM_PHASES   = 4;
  localparam int          LONG_HOLD    = 150;  // receiver hold-off, cycles
  localparam int          SETTLE       = 10;   // extra wait after the checker queue empties
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hrp_in_if  in_ch();
  hrp_out_if out_ch();

  int unsigned mismatches;
  int unsigned pending;

  // idle/stall odds, percent; set per phase by the stimulus
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int unsigned items_sent = 0;

  // stimulus bumps hold_asks; receiver notices and holds off on its own
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int          hold_left = 0;

  int unsigned cycle_count = 0;
  string       hex_chars = "0123456789abcdefABCDEF";

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  http_request_head_parser_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hrp_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .error_count (mismatches),
    .outstanding (pending)
  );

  // Watchdog: generous bound over the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL http_request_head_parser_unit");
      $finish;
    end
  end

  // Receiver: random backpressure, or a long hold-off when asked. While
  // held, the 4-deep queue fills and in_ch.ready must drop.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One input transfer. Drive at negedge, wait for the handshake at posedge.
  // valid gets a single assignment per negedge, so back-to-back transfers
  // keep it high without a glitch.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(CMD_DATA, b);
    items_sent++;
  endtask

  task automatic send_restart();
    send_item(CMD_RESTART, 8'($urandom));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_data(s[i]);
  endtask

  // line end with or without CR
  task automatic send_eol();
    if ($urandom_range(1)) send_data(CH_CR);
    send_data(CH_LF);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(33, 126));
  endfunction

  // char after '%': mostly hex, plus blanks, signs, junk and stray CR
  function automatic logic [7:0] escape_char();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return hex_chars[$urandom_range(21)];
      5:             return $urandom_range(1) ? CH_SP : CH_TAB;
      6:             return $urandom_range(1) ? CH_PLUS : CH_MINUS;
      7:             return 8'($urandom);
      8:             return 8'($urandom_range(103, 122));
      default:       return CH_CR;
    endcase
  endfunction

  // raw noise, weighted toward the parser's delimiters
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(9))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_SP;
      3:       return CH_COLON;
      4:       return CH_PCT;
      5:       return CH_QMARK;
      default: return 8'($urandom);
    endcase
  endfunction

  // One request head: restart, optional leading blank lines, request line,
  // a few headers, blank line, then some bytes the block must ignore.
  // A share of heads is plain noise instead.
  task automatic send_random_head();
    int shape;
    send_restart();
    repeat ($urandom_range(0, 2)) send_eol();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(4, 40)) send_data(noise_byte());
      return;
    end
    repeat ($urandom_range(1, 6)) send_data(8'($urandom_range(65, 90)));
    if ($urandom_range(99) < 10) begin
      // no space: default-path marker
      send_eol();
    end else begin
      send_data(CH_SP);
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(99) < 25) begin
          send_data(CH_PCT);
          send_data(escape_char());
          send_data(escape_char());
        end else begin
          send_data(printable());
        end
      end
      shape = $urandom_range(9);
      if (shape == 0) begin
        // escape cut short by the line end
        send_data(CH_PCT);
        if ($urandom_range(1)) send_data(escape_char());
      end else begin
        if ($urandom_range(99) < 40) begin
          send_data(CH_QMARK);
          repeat ($urandom_range(0, 6)) send_data(printable());
        end
        if (shape <= 7) begin
          send_text(" HTTP/");
          repeat ($urandom_range(1, 4)) send_data(printable());
        end else if (shape == 8) begin
          // broken version tag
          send_text(" HT");
          repeat ($urandom_range(1, 4)) send_data(printable());
        end
      end
      send_eol();
    end
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(99) < 15) begin
        // header without a colon
        repeat ($urandom_range(1, 6)) send_data(8'($urandom_range(97, 122)));
      end else begin
        repeat ($urandom_range(1, 8)) send_data(8'($urandom_range(97, 122)));
        send_data(CH_COLON);
        repeat ($urandom_range(0, 3)) send_data($urandom_range(1) ? CH_SP : CH_TAB);
        repeat ($urandom_range(0, 10)) begin
          case ($urandom_range(19))
            0:       send_data(8'($urandom));
            1, 2:    send_data($urandom_range(1) ? CH_SP : CH_TAB);
            default: send_data(printable());
          endcase
        end
      end
      send_eol();
    end
    send_eol();
    // after head end: taken and ignored, not counted as stimulus
    repeat ($urandom_range(0, 3)) send_item(CMD_DATA, 8'($urandom));
  endtask

  // Sender pause: hold valid low until every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int unsigned goal;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_DATA;
    in_ch.data_byte = 8'd0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed head 1: restart with data 0xFF, skipped CRLF blank line,
    // signed escape, query byte 0xFF, version mismatch, value byte 0x00
    // with CRLF, blank line ending the head, then an ignored byte.
    send_item(CMD_RESTART, 8'hFF);
    items_sent++;
    send_data(CH_CR);
    send_data(CH_LF);
    send_text("G %-f?");
    send_data(8'hFF);
    send_text(" HX");
    send_data(CH_LF);
    send_text("n: ");
    send_data(8'h00);
    send_data(CH_CR);
    send_data(CH_LF);
    send_data(CH_LF);
    send_item(CMD_DATA, 8'h5A);
    // Directed head 2: request line with no space gives the default path.
    send_item(CMD_RESTART, 8'h00);
    items_sent++;
    send_text("AB");
    send_data(CH_LF);
    wait_drained();

    // Random part over the idling phases; each phase ends drained.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 66; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      // long receiver hold-off while the sender keeps pushing
      if (p == 0 || p == NUM_PHASES - 1) hold_asks++;
      goal = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < goal) begin
        send_random_head();
        if ($urandom_range(99) < 10) wait_drained();
      end
      wait_drained();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("PASS http_request_head_parser_unit");
    end else begin
      $display("FAIL http_request_head_parser_unit");
    end
    $finish;
  end

endmodule
